// ===== rtl/bankswitch_cart_mapper_with_ram_unit_defines.svh =====
// Assertion macros for the bankswitch cartridge mapper checker.
// Used by bcm_checker.sv; needs clk and rst in the scope of each use.
`ifndef BANKSWITCH_CART_MAPPER_WITH_RAM_UNIT_DEFINES_SVH
`define BANKSWITCH_CART_MAPPER_WITH_RAM_UNIT_DEFINES_SVH

// Check a property outside reset.
`define BCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bcm_pkg.sv =====
// Shared types and constants for the bankswitch cartridge mapper.
// No dependencies.
`default_nettype none

package bcm_pkg;

  localparam int IMG_DEPTH = 8192;
  localparam int IMG_AW    = 13;
  localparam int RAM_BYTES = 64;
  localparam int RAM_AW    = 6;
  localparam int SEG_AW    = 10;
  localparam int DATA_W    = 8;

  localparam logic       OP_BUS  = 1'b0;
  localparam logic       OP_LOAD = 1'b1;

  localparam logic [1:0]  SWITCH_DELAY = 2'd3;
  localparam logic [11:0] RAM_RD_END   = 12'h040;
  localparam logic [11:0] RAM_WR_END   = 12'h080;
  localparam logic [7:0]  HOT_LO       = 8'h30;
  localparam logic [7:0]  HOT_HI       = 8'h3F;

  localparam logic [2:0] LAYOUT_SEG [8][4] = '{
    '{3'd0, 3'd0, 3'd1, 3'd2},
    '{3'd0, 3'd1, 3'd3, 3'd2},
    '{3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd7, 3'd4, 3'd3, 3'd2},
    '{3'd0, 3'd0, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd7, 3'd6},
    '{3'd3, 3'd2, 3'd4, 3'd5},
    '{3'd6, 3'd0, 3'd5, 3'd1}
  };

  typedef struct packed {
    logic              img_we;
    logic              img_re;
    logic              ram_we;
    logic              ram_re;
    logic [IMG_AW-1:0] img_addr;
    logic [RAM_AW-1:0] ram_addr;
  } req_t;

endpackage

`default_nettype wire

// ===== rtl/bcm_ram.sv =====
// Generic simple dual-port RAM with registered, enabled read.
// No dependencies.
`default_nettype none

module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcm_ctrl.sv =====
// Layout switch state and address decode for one transaction.
// Depends on bcm_pkg.
`default_nettype none

module bcm_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         op,
  input  wire logic [bcm_pkg::IMG_AW-1:0]   address,
  output bcm_pkg::req_t                     req
);

  logic [2:0] active_layout, active_layout_next;
  logic       switch_armed, switch_armed_next;
  logic [2:0] armed_layout, armed_layout_next;
  logic [1:0] delay_count, delay_count_next;
  logic [2:0] layout_now;
  logic       armed_now;
  logic [1:0] delay_now;
  logic [11:0] off;
  logic        hotspot;

  assign off     = address[11:0];
  assign hotspot = !address[12] && (address[7:0] >= bcm_pkg::HOT_LO)
                   && (address[7:0] <= bcm_pkg::HOT_HI);

  always_comb begin
    layout_now = active_layout;
    armed_now  = switch_armed;
    delay_now  = delay_count;
    if (switch_armed) begin
      if (delay_count == 2'd0) begin
        layout_now = armed_layout;
        armed_now  = 1'b0;
      end else begin
        delay_now = delay_count - 2'd1;
      end
    end

    active_layout_next = active_layout;
    switch_armed_next  = switch_armed;
    armed_layout_next  = armed_layout;
    delay_count_next   = delay_count;
    if (accept && op == bcm_pkg::OP_BUS) begin
      active_layout_next = layout_now;
      switch_armed_next  = armed_now;
      delay_count_next   = delay_now;
      if (hotspot) begin
        switch_armed_next = 1'b1;
        armed_layout_next = address[2:0];
        delay_count_next  = bcm_pkg::SWITCH_DELAY;
      end
    end
  end

  always_comb begin
    req          = '0;
    req.ram_addr = off[bcm_pkg::RAM_AW-1:0];
    req.img_addr = {bcm_pkg::LAYOUT_SEG[layout_now][off[11:10]],
                    off[bcm_pkg::SEG_AW-1:0]};
    if (op == bcm_pkg::OP_LOAD) begin
      req.img_we   = 1'b1;
      req.img_addr = address;
    end else if (address[12]) begin
      if (off < bcm_pkg::RAM_RD_END) begin
        req.ram_re = 1'b1;
      end else if (off < bcm_pkg::RAM_WR_END) begin
        req.ram_we = 1'b1;
      end else begin
        req.img_re = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_layout <= 3'd0;
      switch_armed  <= 1'b0;
      armed_layout  <= 3'd0;
      delay_count   <= 2'd0;
    end else begin
      active_layout <= active_layout_next;
      switch_armed  <= switch_armed_next;
      armed_layout  <= armed_layout_next;
      delay_count   <= delay_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bankswitch_cart_mapper_with_ram_unit.sv =====
// Bankswitch cartridge mapper with 64 bytes of RAM: top level.
// Depends on bcm_pkg, bcm_ctrl and bcm_ram.
//
// Input channel (in_valid/in_stall) carries op, address and bus_data: a bus
// cycle or the load of one image byte. Output channel (out_valid/out_stall)
// returns read_data and drive_bus, one result transaction per input.
// The accepting edge loads the registered RAM/image read into the read
// stage; when the output is free, the stage moves into the output register.
// Throughput: one transaction per cycle while in_stall is low; each item
// does at most one access to one of the two memories.
// Reset clears the layout switch state and marks all 64 RAM bytes as zero
// through per-byte written flags; the image RAM is not cleared and holds its
// contents. Reset takes effect at once, no clearing pass.
// When out_stall holds the output, the read stage fills and then in_stall
// rises; no transaction is dropped and stalled outputs hold.
`default_nettype none

module bankswitch_cart_mapper_with_ram_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               op,
  input  wire logic [bcm_pkg::IMG_AW-1:0]         address,
  input  wire logic [bcm_pkg::DATA_W-1:0]         bus_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [bcm_pkg::DATA_W-1:0]         read_data,
  output logic                                    drive_bus
);

  bcm_pkg::req_t                    req;
  logic                             accept;
  logic                             out_ready;
  logic                             s1_move;
  logic                             s1_valid;
  logic                             s1_drive;
  logic                             s1_from_ram;
  logic                             s1_ram_vld;
  logic [bcm_pkg::RAM_BYTES-1:0]    ram_written;
  logic [bcm_pkg::DATA_W-1:0]       img_rdata;
  logic [bcm_pkg::DATA_W-1:0]       ram_rdata;
  logic [bcm_pkg::DATA_W-1:0]       s1_data;

  assign out_ready = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign accept    = in_valid && !in_stall;

  bcm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (op),
    .address (address),
    .req     (req)
  );

  bcm_ram #(
    .WIDTH (bcm_pkg::DATA_W),
    .DEPTH (bcm_pkg::IMG_DEPTH)
  ) u_img (
    .clk   (clk),
    .we    (accept && req.img_we),
    .waddr (req.img_addr),
    .wdata (bus_data),
    .re    (accept && req.img_re),
    .raddr (req.img_addr),
    .rdata (img_rdata)
  );

  bcm_ram #(
    .WIDTH (bcm_pkg::DATA_W),
    .DEPTH (bcm_pkg::RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (accept && req.ram_we),
    .waddr (req.ram_addr),
    .wdata (bus_data),
    .re    (accept && req.ram_re),
    .raddr (req.ram_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_data = '0;
    if (s1_drive) begin
      if (s1_from_ram) begin
        s1_data = s1_ram_vld ? ram_rdata : '0;
      end else begin
        s1_data = img_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      ram_written <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && req.ram_we) begin
        ram_written[req.ram_addr] <= 1'b1;
      end
    end
  end

  // Hold payload while the stage waits.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_drive    <= req.ram_re || req.img_re;
      s1_from_ram <= req.ram_re;
      s1_ram_vld  <= ram_written[req.ram_addr];
    end
    if (s1_move) begin
      read_data <= s1_data;
      drive_bus <= s1_drive;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcm_checker.sv =====
// Port-level checks for the bankswitch cartridge mapper, bound to the top.
// Depends on bankswitch_cart_mapper_with_ram_unit_defines.svh.
`default_nettype none
`include "bankswitch_cart_mapper_with_ram_unit_defines.svh"

module bcm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] read_data,
  input wire logic       drive_bus
);

  `BCM_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "output valid after reset")
  `BCM_ASSERT(a_quiet_zero, (out_valid && !drive_bus) |-> (read_data == 8'd0), "nonzero undriven data")
  `BCM_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without output stall")
  `BCM_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(drive_bus)), "stalled transaction changed")

endmodule

bind bankswitch_cart_mapper_with_ram_unit bcm_checker u_bcm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .read_data (read_data),
  .drive_bus (drive_bus)
);

`default_nettype wire
